### sv/quadratic_root_solver_defines.svh
// assertion macros for the quadratic root solver
// used by quadratic_root_solver.sv; needs clock and reset in scope
`ifndef QUADRATIC_ROOT_SOLVER_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_DEFINES_SVH

// same-cycle implication, quiet during reset
`define QRS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, quiet during reset
`define QRS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/qrs_pkg.sv
// request and response types and class codes of the quadratic root solver
// no dependencies
package qrs_pkg;

   // root class codes
   localparam logic [1:0] CLS_NOT_QUAD = 2'd0;
   localparam logic [1:0] CLS_ONE      = 2'd1;
   localparam logic [1:0] CLS_TWO      = 2'd2;
   localparam logic [1:0] CLS_NONE     = 2'd3;

   typedef struct packed {
      logic signed [15:0] coef_a;
      logic signed [15:0] coef_b;
      logic signed [15:0] coef_c;
   } qrs_req_type;

   typedef struct packed {
      logic [1:0]         root_class;
      logic signed [39:0] root_plus;
      logic signed [39:0] root_minus;
   } qrs_rsp_type;

endpackage

### sv/quadratic_root_solver.sv
// real roots of a*x^2+b*x+c in fixed point, fully pipelined
// depends on qrs_pkg and quadratic_root_solver_defines.svh

// One request (three signed Q8.8 coefficients) can enter every clock while req_stall
// is low, and one response leaves per request, in order. Most of the stages
// belong to the square root (two result bits per stage, nine stages) and the
// two dividers (four quotient bits per stage, eight stages). Each stage holds
// its item while the stage after it cannot move, so bubbles close up under a
// stall and req_stall only rises when every stage is occupied and the response
// is not taken.

`include "quadratic_root_solver_defines.svh"

module quadratic_root_solver
   import qrs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  qrs_req_type req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output qrs_rsp_type rsp_payload
);

   localparam int SQ_STG   = 9;
   localparam int DV_STG   = 8;
   localparam int SL_IN    = 0;
   localparam int SL_PROD  = 1;
   localparam int SL_SEED  = 2;
   localparam int SL_SQ    = 3;
   localparam int SL_NUM   = SL_SQ + SQ_STG;
   localparam int SL_DV    = SL_NUM + 1;
   localparam int SL_OUT   = SL_DV + DV_STG;
   localparam int NSLOT    = SL_OUT + 1;

   typedef struct packed {
      logic [1:0]         cls;
      logic signed [15:0] a;
      logic signed [15:0] b;
      logic [35:0]        rad;
      logic [17:0]        rem;
      logic [17:0]        root;
   } sq_type;

   typedef struct packed {
      logic [1:0]  cls;
      logic        neg_p;
      logic        neg_m;
      logic [15:0] dvs;
      logic [15:0] rem_p;
      logic [15:0] rem_m;
      logic [31:0] q_p;
      logic [31:0] q_m;
   } dv_type;

   // one digit of the square root
   function automatic sq_type sq_step(input sq_type s);
      sq_type      r;
      logic [19:0] t;
      logic [19:0] cand;
      r    = s;
      t    = {s.rem, s.rad[35:34]};
      cand = {s.root, 2'b01};
      if (t >= cand) begin
         r.rem  = 18'(t - cand);
         r.root = {s.root[16:0], 1'b1};
      end else begin
         r.rem  = t[17:0];
         r.root = {s.root[16:0], 1'b0};
      end
      r.rad = {s.rad[33:0], 2'b00};
      return r;
   endfunction

   // one quotient bit for both dividers
   function automatic dv_type dv_step(input dv_type d);
      dv_type      r;
      logic [16:0] tp;
      logic [16:0] tm;
      logic        bp;
      logic        bm;
      r  = d;
      tp = {d.rem_p, d.q_p[31]};
      tm = {d.rem_m, d.q_m[31]};
      bp = (tp >= {1'b0, d.dvs});
      bm = (tm >= {1'b0, d.dvs});
      r.rem_p = bp ? 16'(tp - {1'b0, d.dvs}) : tp[15:0];
      r.rem_m = bm ? 16'(tm - {1'b0, d.dvs}) : tm[15:0];
      r.q_p   = {d.q_p[30:0], bp};
      r.q_m   = {d.q_m[30:0], bm};
      return r;
   endfunction

   logic [NSLOT-1:0] valid_ff;
   logic [NSLOT-1:0] valid_in;
   logic [NSLOT-1:0] adv;

   qrs_req_type        in_ff;
   logic [30:0]        bb_ff;
   logic [30:0]        bb_in;
   logic signed [31:0] ac_ff;
   logic signed [31:0] ac_in;
   logic signed [15:0] pa_ff;
   logic signed [15:0] pb_ff;
   sq_type             seed_ff;
   sq_type             seed_in;
   sq_type             sq_ff [SQ_STG];
   sq_type             sq_in [SQ_STG];
   dv_type             num_ff;
   dv_type             num_in;
   dv_type             dv_ff [DV_STG];
   dv_type             dv_in [DV_STG];
   qrs_rsp_type        rsp_ff;
   qrs_rsp_type        rsp_in;

   // advance chain: a slot moves when it is empty or its successor moves
   always_comb begin
      adv[NSLOT-1] = !valid_ff[NSLOT-1] || !rsp_stall;
      for (int k = NSLOT - 2; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
      valid_in[0] = req_valid;
      for (int k = 1; k < NSLOT; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
   end

   assign req_stall = !adv[SL_IN];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NSLOT; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   // products b*b and a*c
   always_comb begin
      bb_in = 31'($unsigned(32'(in_ff.coef_b * in_ff.coef_b)));
      ac_in = 32'(in_ff.coef_a * in_ff.coef_c);
   end

   // discriminant, class and square root seed
   always_comb begin
      logic signed [34:0] d;
      d = $signed({4'b0000, bb_ff}) - ($signed({{3{ac_ff[31]}}, ac_ff}) <<< 2);
      seed_in.a    = pa_ff;
      seed_in.b    = pb_ff;
      seed_in.rem  = '0;
      seed_in.root = '0;
      seed_in.rad  = '0;
      if (pa_ff == 16'sd0) begin
         seed_in.cls = CLS_NOT_QUAD;
      end else if (d == 35'sd0) begin
         seed_in.cls = CLS_ONE;
      end else if (d > 35'sd0) begin
         seed_in.cls = CLS_TWO;
         seed_in.rad = {1'b0, d};
      end else begin
         seed_in.cls = CLS_NONE;
      end
   end

   // square root stages, two digits each
   always_comb begin
      for (int k = 0; k < SQ_STG; k++) begin
         sq_in[k] = sq_step(sq_step((k == 0) ? seed_ff : sq_ff[k-1]));
      end
   end

   // numerators, signs and divider operands
   always_comb begin
      logic signed [18:0] nb;
      logic signed [18:0] s;
      logic signed [18:0] np;
      logic signed [18:0] nm;
      logic [18:0]        mp;
      logic [18:0]        mm;
      sq_type             q;
      q  = sq_ff[SQ_STG-1];
      nb = -$signed({{3{q.b[15]}}, q.b});
      s  = $signed({2'b00, q.root[16:0]});
      np = nb + s;
      nm = nb - s;
      mp = np[18] ? 19'(-np) : 19'(np);
      mm = nm[18] ? 19'(-nm) : 19'(nm);
      num_in.cls   = q.cls;
      num_in.neg_p = np[18] ^ q.a[15];
      num_in.neg_m = nm[18] ^ q.a[15];
      num_in.dvs   = q.a[15] ? 16'(-q.a) : 16'(q.a);
      num_in.rem_p = '0;
      num_in.rem_m = '0;
      num_in.q_p   = {mp[16:0], 15'b0};
      num_in.q_m   = {mm[16:0], 15'b0};
   end

   // divider stages, four quotient bits each
   always_comb begin
      for (int k = 0; k < DV_STG; k++) begin
         dv_in[k] = dv_step(dv_step(dv_step(dv_step((k == 0) ? num_ff : dv_ff[k-1]))));
      end
   end

   // signs applied, unused roots forced to zero
   always_comb begin
      dv_type             d;
      logic signed [39:0] vp;
      logic signed [39:0] vm;
      d  = dv_ff[DV_STG-1];
      vp = $signed({8'b0, d.q_p});
      vm = $signed({8'b0, d.q_m});
      rsp_in.root_class = d.cls;
      rsp_in.root_plus  = '0;
      rsp_in.root_minus = '0;
      if (d.cls == CLS_ONE || d.cls == CLS_TWO) begin
         rsp_in.root_plus = d.neg_p ? -vp : vp;
      end
      if (d.cls == CLS_TWO) begin
         rsp_in.root_minus = d.neg_m ? -vm : vm;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (adv[SL_IN]) begin
         in_ff <= req_payload;
      end
      if (adv[SL_PROD]) begin
         bb_ff <= bb_in;
         ac_ff <= ac_in;
         pa_ff <= in_ff.coef_a;
         pb_ff <= in_ff.coef_b;
      end
      if (adv[SL_SEED]) begin
         seed_ff <= seed_in;
      end
      for (int k = 0; k < SQ_STG; k++) begin
         if (adv[SL_SQ + k]) begin
            sq_ff[k] <= sq_in[k];
         end
      end
      if (adv[SL_NUM]) begin
         num_ff <= num_in;
      end
      for (int k = 0; k < DV_STG; k++) begin
         if (adv[SL_DV + k]) begin
            dv_ff[k] <= dv_in[k];
         end
      end
      if (adv[SL_OUT]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = valid_ff[SL_OUT];
   assign rsp_payload = rsp_ff;

   // checks
   `QRS_ASSERT_NOW(a_stall_source, req_stall, (&valid_ff) && rsp_stall, "stall without full pipe")
   `QRS_ASSERT_NOW(a_zero_roots, rsp_valid && (rsp_payload.root_class == CLS_NOT_QUAD || rsp_payload.root_class == CLS_NONE), rsp_payload.root_plus == 40'sd0 && rsp_payload.root_minus == 40'sd0, "absent roots not zero")
   `QRS_ASSERT_NOW(a_one_root, rsp_valid && rsp_payload.root_class == CLS_ONE, rsp_payload.root_minus == 40'sd0, "double root minus not zero")
   `QRS_ASSERT_NEXT(a_drain, rsp_valid && !rsp_stall && !valid_ff[SL_OUT-1], !rsp_valid, "response repeated")

endmodule

### verif/tb.sv
// testbench for quadratic_root_solver: directed and random coefficient sets,
// responses checked in order against a fixed-point root predictor; needs qrs_pkg
module tb;
   import qrs_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // in-order store of predicted roots
   class root_board;
      qrs_rsp_type pending[$];
      int errors = 0;

      // floor integer square root
      function automatic longint unsigned floor_sqrt(longint unsigned v);
         longint unsigned r;
         r = 0;
         for (int k = 31; k >= 0; k--) begin
            if ((r | (64'd1 << k)) * (r | (64'd1 << k)) <= v)
               r = r | (64'd1 << k);
         end
         return r;
      endfunction

      function void note_request(qrs_req_type q);
         longint a, b, c, delta, den, s;
         qrs_rsp_type r;
         a = q.coef_a;
         b = q.coef_b;
         c = q.coef_c;
         r.root_plus = '0;
         r.root_minus = '0;
         if (a == 0) begin
            r.root_class = CLS_NOT_QUAD;
         end else begin
            delta = b * b - 4 * a * c;
            den = 2 * a;
            if (delta == 0) begin
               r.root_class = CLS_ONE;
               r.root_plus = 40'((-b * 65536) / den);
            end else if (delta > 0) begin
               s = longint'(floor_sqrt(delta));
               r.root_class = CLS_TWO;
               r.root_plus = 40'(((-b + s) * 65536) / den);
               r.root_minus = 40'(((-b - s) * 65536) / den);
            end else begin
               r.root_class = CLS_NONE;
            end
         end
         pending.push_back(r);
      endfunction

      function void check_response(qrs_rsp_type got);
         qrs_rsp_type e;
         if (pending.size() == 0) begin
            $error("response with no request pending");
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.root_class !== e.root_class) begin
            $error("root_class expected %0d actual %0d", e.root_class, got.root_class);
            errors++;
         end
         if (got.root_plus !== e.root_plus) begin
            $error("root_plus expected %0d actual %0d", e.root_plus, got.root_plus);
            errors++;
         end
         if (got.root_minus !== e.root_minus) begin
            $error("root_minus expected %0d actual %0d", e.root_minus, got.root_minus);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   qrs_req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   qrs_rsp_type rsp_payload;
   int send_idle = 0;
   int recv_idle = 0;
   root_board board = new();

   quadratic_root_solver uut (.*);

   always #6 clock = ~clock;

   // response side: random stall, check on accept
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_response(rsp_payload);
      rsp_stall <= ($urandom_range(99) < recv_idle);
   end

   // one request, held until taken
   task automatic send_request(logic signed [15:0] a, logic signed [15:0] b,
                               logic signed [15:0] c);
      qrs_req_type q;
      q.coef_a = a;
      q.coef_b = b;
      q.coef_c = c;
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_payload <= q;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(q);
   endtask

   // random set: full range most often, else small values, zero delta or a = 0
   task automatic send_random();
      logic signed [15:0] a, b, c;
      logic signed [15:0] r;
      int m;
      m = int'($urandom_range(9));
      if (m < 4) begin
         a = 16'($urandom);
         b = 16'($urandom);
         c = 16'($urandom);
      end else if (m < 7) begin
         a = 16'($signed($urandom_range(600)) - 300);
         b = 16'($signed($urandom_range(600)) - 300);
         c = 16'($signed($urandom_range(600)) - 300);
      end else if (m < 9) begin
         // perfect square: a(x-r)^2 with b = -2ar, c = a r^2
         a = 16'($signed($urandom_range(40)) - 20);
         r = 16'($signed($urandom_range(60)) - 30);
         b = 16'(-2 * a * r);
         c = 16'(a * r * r);
      end else begin
         a = '0;
         b = 16'($urandom);
         c = 16'($urandom);
      end
      send_request(a, b, c);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 0;
      send_idle = 38;
      recv_idle = 70;
      // directed corner cases
      send_request(16'sh0000, 16'sh0000, 16'sh0000);
      send_request(16'sh0000, 16'sh7fff, 16'sh8000);
      send_request(16'sh0100, 16'shfe00, 16'sh0100);
      send_request(16'sh0100, 16'sh0300, 16'sh0200);
      send_request(16'sh0100, 16'sh0000, 16'sh0100);
      send_request(16'sh7fff, 16'sh8000, 16'sh8000);
      send_request(16'sh8000, 16'sh8000, 16'sh7fff);
      send_request(16'sh8000, 16'sh7fff, 16'sh8000);
      send_request(16'sh0001, 16'sh7fff, 16'sh0000);
      send_request(16'shffff, 16'sh8000, 16'sh0000);
      send_request(16'sh0001, 16'sh0002, 16'sh0001);
      send_request(16'shffff, 16'sh0001, 16'sh0000);
      send_request(16'sh7fff, 16'sh0000, 16'sh7fff);
      send_request(16'shffff, 16'shffff, 16'shffff);
      send_request(16'sh0001, 16'sh0001, 16'sh0001);
      send_request(16'sh0001, 16'sh0003, 16'sh0002);
      send_request(16'sh0002, 16'sh0000, 16'sh0000);
      // random phases
      for (int i = 0; i < 180; i++) send_random();
      send_idle = 70;
      recv_idle = 38;
      for (int i = 0; i < 180; i++) send_random();
      send_idle = 0;
      recv_idle = 0;
      for (int i = 0; i < 190; i++) send_random();
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (board.errors == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

   // watchdog
   initial begin
      #5ms;
      $display("tb NOT OK");
      $finish;
   end
endmodule
